/* sv/pat_pkg.sv */
// Package for the pending acknowledgement tracker.
// Holds the transaction payload types, the command codes and the control state type.
// Depends on nothing.
package pat_pkg;

    localparam int SEQ_W = 16;
    localparam int SENDER_W = 8;
    localparam int SLOT_INDEX_W = 3;
    localparam int ACKED_W = 32;

    localparam logic CMD_RECORD = 1'b0;
    localparam logic CMD_ACK = 1'b1;

    typedef struct packed {
        logic                cmd;
        logic                is_broadcast;
        logic [SENDER_W-1:0] sender_id;
        logic [SEQ_W-1:0]    ack_seq;
    } t_in;

    typedef struct packed {
        logic [SEQ_W-1:0]        seq_number;
        logic                    slot_hit;
        logic [SLOT_INDEX_W-1:0] slot_index;
        logic                    slot_freed;
        logic [ACKED_W-1:0]      acked_boards;
    } t_out;

    typedef enum logic {
        ST_IDLE,
        ST_UPDATE
    } t_state;

endpackage

/* sv/pending_ack_tracker.sv */
// Pending acknowledgement tracker: slot flags in flip-flops, bitmaps in a synchronous RAM.
// An item is accepted in ST_IDLE and updates the table in ST_UPDATE, which stalls until the
// output register is free; no new item enters meanwhile. The bitmap RAM is read on acceptance
// and written back on the update. The next item may enter while the registered result waits.
// Reset clears the sequence counter, the slot valid bits, the control state and the output valid.
// Depends on pat_pkg.
module pending_ack_tracker #(
    parameter int PENDING_SLOTS = 8,
    parameter int MAX_BOARDS = 32
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_in_valid,
    output logic          o_in_ready,
    input  pat_pkg::t_in  i_in_data,
    output logic          o_out_valid,
    input  logic          i_out_ready,
    output pat_pkg::t_out o_out_data
);

    localparam int IDX_W = (PENDING_SLOTS > 1) ? $clog2(PENDING_SLOTS) : 1;

    pat_pkg::t_state r_state;
    pat_pkg::t_state n_state;

    logic [pat_pkg::SEQ_W-1:0]    r_seq_cnt;
    logic [PENDING_SLOTS-1:0]     r_active;
    logic [PENDING_SLOTS-1:0]     r_bcast;
    logic [pat_pkg::SEQ_W-1:0]    r_slot_seq [PENDING_SLOTS];
    logic [MAX_BOARDS-1:0]        r_ack_mem [PENDING_SLOTS];
    logic [MAX_BOARDS-1:0]        r_rdata;

    logic                         r_cmd;
    logic                         r_is_bcast;
    logic [pat_pkg::SENDER_W-1:0] r_sender;
    logic [pat_pkg::SEQ_W-1:0]    r_ack_seq;
    logic                         r_hit;
    logic [IDX_W-1:0]             r_idx;

    logic          r_out_valid;
    pat_pkg::t_out r_out;
    pat_pkg::t_out n_out;

    logic                          w_accept;
    logic                          w_out_free;
    logic                          w_commit;
    logic                          w_find_any;
    logic [IDX_W-1:0]              w_find_idx;
    logic [MAX_BOARDS-1:0]         w_sender_mask;
    logic [MAX_BOARDS-1:0]         w_new_acks;
    logic [MAX_BOARDS-1:0]         w_mem_wdata;
    logic [MAX_BOARDS+pat_pkg::ACKED_W-1:0] w_acks_ext;
    logic [IDX_W+pat_pkg::SLOT_INDEX_W-1:0] w_idx_ext;
    logic [pat_pkg::SEQ_W-1:0]     w_seq_next;
    logic                          w_mem_we;

    assign w_accept   = i_in_valid && o_in_ready;
    assign w_out_free = !r_out_valid || i_out_ready;
    assign w_commit   = (r_state == pat_pkg::ST_UPDATE) && w_out_free;
    assign w_seq_next = r_seq_cnt + pat_pkg::SEQ_W'(1);

    always_comb begin
        w_find_any = 1'b0;
        w_find_idx = '0;
        for (int s = PENDING_SLOTS - 1; s >= 0; s--) begin
            if (i_in_data.cmd == pat_pkg::CMD_RECORD) begin
                if (!r_active[s]) begin
                    w_find_any = 1'b1;
                    w_find_idx = IDX_W'(s);
                end
            end else begin
                if (r_active[s] && (r_slot_seq[s] == i_in_data.ack_seq)) begin
                    w_find_any = 1'b1;
                    w_find_idx = IDX_W'(s);
                end
            end
        end
    end

    always_comb begin
        for (int b = 0; b < MAX_BOARDS; b++) begin
            w_sender_mask[b] = (r_sender == pat_pkg::SENDER_W'(b + 1));
        end
    end

    assign w_new_acks  = r_rdata | w_sender_mask;
    assign w_mem_wdata = (r_cmd == pat_pkg::CMD_RECORD) ? '0 : w_new_acks;
    assign w_acks_ext  = {{pat_pkg::ACKED_W{1'b0}}, w_new_acks};
    assign w_idx_ext   = {{pat_pkg::SLOT_INDEX_W{1'b0}}, r_idx};

    always_comb begin
        case (r_state)
            pat_pkg::ST_IDLE: begin
                n_state = w_accept ? pat_pkg::ST_UPDATE : pat_pkg::ST_IDLE;
            end
            pat_pkg::ST_UPDATE: begin
                n_state = w_out_free ? pat_pkg::ST_IDLE : pat_pkg::ST_UPDATE;
            end
            default: begin
                n_state = pat_pkg::ST_IDLE;
            end
        endcase
    end

    always_comb begin
        o_in_ready = 1'b0;
        w_mem_we   = 1'b0;
        case (r_state)
            pat_pkg::ST_IDLE: begin
                o_in_ready = 1'b1;
            end
            pat_pkg::ST_UPDATE: begin
                w_mem_we = w_out_free && r_hit;
            end
            default: begin
                o_in_ready = 1'b0;
            end
        endcase
    end

    always_comb begin
        n_out = '0;
        if (r_cmd == pat_pkg::CMD_RECORD) begin
            n_out.seq_number = w_seq_next;
        end else begin
            n_out.seq_number = r_ack_seq;
        end
        if (r_hit) begin
            n_out.slot_hit   = 1'b1;
            n_out.slot_index = w_idx_ext[pat_pkg::SLOT_INDEX_W-1:0];
            if (r_cmd == pat_pkg::CMD_ACK) begin
                n_out.slot_freed   = !r_bcast[r_idx];
                n_out.acked_boards = w_acks_ext[pat_pkg::ACKED_W-1:0];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= pat_pkg::ST_IDLE;
            r_seq_cnt   <= '0;
            r_active    <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            if (w_commit) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
            if (w_commit && (r_cmd == pat_pkg::CMD_RECORD)) begin
                r_seq_cnt <= w_seq_next;
            end
            if (w_commit && r_hit) begin
                if (r_cmd == pat_pkg::CMD_RECORD) begin
                    r_active[r_idx] <= 1'b1;
                end else if (!r_bcast[r_idx]) begin
                    r_active[r_idx] <= 1'b0;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_cmd      <= i_in_data.cmd;
            r_is_bcast <= i_in_data.is_broadcast;
            r_sender   <= i_in_data.sender_id;
            r_ack_seq  <= i_in_data.ack_seq;
            r_hit      <= w_find_any;
            r_idx      <= w_find_idx;
        end
        if (w_commit) begin
            r_out <= n_out;
        end
        if (w_commit && r_hit && (r_cmd == pat_pkg::CMD_RECORD)) begin
            r_slot_seq[r_idx] <= w_seq_next;
            r_bcast[r_idx]    <= r_is_bcast;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_mem_we) begin
            r_ack_mem[r_idx] <= w_mem_wdata;
        end
        if (w_accept) begin
            r_rdata <= r_ack_mem[w_find_idx];
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;

`ifndef SYNTHESIS
    a_one_item_at_a_time: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_accept |=> !o_in_ready)
        else $error("A second transaction was accepted while one was in progress.");

    a_result_follows_update: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(o_out_valid) |-> $past(r_state == pat_pkg::ST_UPDATE))
        else $error("A result appeared without a table update.");

    a_claimed_slot_active: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_commit && r_hit && (r_cmd == pat_pkg::CMD_RECORD)) |=> r_active[$past(r_idx)])
        else $error("A claimed slot is not marked active.");

    a_active_grows_by_one: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ##1 ($countones(r_active) <= $countones($past(r_active)) + 1))
        else $error("More than one slot was claimed in a cycle.");

    a_freed_implies_hit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_commit && !r_hit) |=> !r_out.slot_freed && !r_out.slot_hit)
        else $error("A missed lookup reported a slot.");
`endif

endmodule
